// ===== rtl/core/tcmp_pkg.sv =====
`default_nettype none

package tcmp_pkg;

  // Sizing of the kept certificate set and the per-entry length limit.
  localparam int unsigned MaxCerts   = 8;
  localparam logic [23:0] MaxCertLen = 24'd8192;

  // One input beat: a message byte and the end-of-message marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } byte_beat_t;

  // One result beat: a certificate byte or the final status.
  typedef struct packed {
    logic       out_kind;
    logic [7:0] cert_byte;
    logic [2:0] cert_index;
    logic       cert_end;
    logic [2:0] status;
    logic [3:0] cert_count;
  } result_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcmp_in_if.sv =====
`default_nettype none

interface tcmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcmp_out_if.sv =====
`default_nettype none

interface tcmp_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] cert_byte;
  logic [2:0] cert_index;
  logic       cert_end;
  logic [2:0] status;
  logic [3:0] cert_count;

  modport source (
    output valid, output out_kind, output cert_byte, output cert_index,
    output cert_end, output status, output cert_count, input ready
  );
  modport sink (
    input valid, input out_kind, input cert_byte, input cert_index,
    input cert_end, input status, input cert_count, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/tcmp_in_reg.sv =====
`default_nettype none

module tcmp_in_reg (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  input  tcmp_pkg::byte_beat_t    in_beat_i,
  output logic                    in_ready_o,
  input  wire                     down_ready_i,
  output logic                    beat_valid_o,
  output tcmp_pkg::byte_beat_t    beat_o
);

  logic                 valid_q;
  tcmp_pkg::byte_beat_t beat_q;
  logic                 take;

  // The held beat leaves when the parser stage can move it on.
  assign take       = valid_q && down_ready_i;
  assign in_ready_o = !valid_q || take;

  // Valid flag of the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

// ===== rtl/core/tcmp_parse.sv =====
`default_nettype none

module tcmp_parse (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     beat_valid_i,
  input  tcmp_pkg::byte_beat_t    beat_i,
  input  wire                     down_ready_i,
  output logic                    res_valid_o,
  output tcmp_pkg::result_beat_t  res_o
);

  // Parser phases.
  localparam logic [2:0] PhHdr     = 3'd0;
  localparam logic [2:0] PhCtxLen  = 3'd1;
  localparam logic [2:0] PhCtx     = 3'd2;
  localparam logic [2:0] PhListLen = 3'd3;
  localparam logic [2:0] PhEntLen  = 3'd4;
  localparam logic [2:0] PhCert    = 3'd5;
  localparam logic [2:0] PhExtLen  = 3'd6;
  localparam logic [2:0] PhExt     = 3'd7;

  // Final status codes.
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTruncated = 3'd1;
  localparam logic [2:0] StMismatch  = 3'd2;
  localparam logic [2:0] StBadEntry  = 3'd3;
  localparam logic [2:0] StNone      = 3'd4;

  // Result kinds.
  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [3:0] MaxKept = 4'(tcmp_pkg::MaxCerts);

  logic [2:0]  phase_q, phase_d;
  logic [23:0] fc_q, fc_d;
  logic [23:0] acc_q, acc_d;
  logic [23:0] lrem_q, lrem_d;
  logic [3:0]  kept_q, kept_d;
  logic        seen_q, seen_d;
  logic        mism_q, mism_d;
  logic        bad_q, bad_d;

  logic        step;
  logic [7:0]  b;
  logic [23:0] fc_inc;
  logic [23:0] fc_dec;
  logic [23:0] lrem_dec;
  logic [23:0] acc_shift;
  logic [15:0] ext_len;
  logic [24:0] len_plus2;
  logic        emit;
  tcmp_pkg::result_beat_t res;
  logic [2:0]  st;

  assign step      = beat_valid_i && down_ready_i;
  assign b         = beat_i.in_byte;
  assign fc_inc    = fc_q + 24'd1;
  assign fc_dec    = fc_q - 24'd1;
  assign lrem_dec  = lrem_q - 24'd1;
  assign acc_shift = {acc_q[15:0], b};
  assign ext_len   = {acc_q[7:0], b};
  assign len_plus2 = {1'b0, acc_shift} + 25'd2;

  // Next state of the message walk for the current byte.
  always_comb begin
    phase_d = phase_q;
    fc_d    = fc_q;
    acc_d   = acc_q;
    lrem_d  = lrem_q;
    kept_d  = kept_q;
    seen_d  = seen_q;
    mism_d  = mism_q;
    bad_d   = bad_q;
    emit    = 1'b0;
    unique case (phase_q)
      PhHdr: begin
        fc_d = fc_inc;
        if (fc_inc >= 24'd4) begin
          phase_d = PhCtxLen;
          fc_d    = '0;
        end
      end
      PhCtxLen: begin
        acc_d = '0;
        if (b == 8'd0) begin
          phase_d = PhListLen;
          fc_d    = '0;
        end else begin
          phase_d = PhCtx;
          fc_d    = {16'd0, b};
        end
      end
      PhCtx: begin
        fc_d = fc_dec;
        if (fc_dec == 24'd0) begin
          phase_d = PhListLen;
          acc_d   = '0;
        end
      end
      PhListLen: begin
        acc_d = acc_shift;
        fc_d  = fc_inc;
        if (fc_inc >= 24'd3) begin
          lrem_d  = acc_shift;
          phase_d = PhEntLen;
          fc_d    = '0;
          acc_d   = '0;
        end
      end
      default: begin
        // Byte inside the certificate list.
        if (lrem_q == 24'd0) begin
          mism_d = 1'b1;
        end else begin
          lrem_d = lrem_dec;
          if (!bad_q) begin
            case (phase_q)
              PhEntLen: begin
                if (fc_q == 24'd0 && lrem_q < 24'd3) begin
                  bad_d = 1'b1;
                end else begin
                  acc_d = acc_shift;
                  fc_d  = fc_inc;
                  if (fc_inc == 24'd3) begin
                    if (acc_shift == 24'd0 || acc_shift > tcmp_pkg::MaxCertLen ||
                        len_plus2 > {1'b0, lrem_dec}) begin
                      bad_d = 1'b1;
                    end else begin
                      seen_d  = (kept_q < MaxKept);
                      kept_d  = (kept_q < MaxKept) ? kept_q + 4'd1 : kept_q;
                      phase_d = PhCert;
                      fc_d    = acc_shift;
                      acc_d   = '0;
                    end
                  end
                end
              end
              PhCert: begin
                fc_d = fc_dec;
                emit = seen_q;
                if (fc_dec == 24'd0) begin
                  phase_d = PhExtLen;
                  acc_d   = '0;
                end
              end
              PhExtLen: begin
                acc_d = {8'd0, ext_len};
                fc_d  = fc_inc;
                if (fc_inc == 24'd2) begin
                  if ({8'd0, ext_len} > lrem_dec) begin
                    bad_d = 1'b1;
                  end else if (ext_len == 16'd0) begin
                    phase_d = PhEntLen;
                    fc_d    = '0;
                    acc_d   = '0;
                  end else begin
                    phase_d = PhExt;
                    fc_d    = {8'd0, ext_len};
                    acc_d   = '0;
                  end
                end
              end
              default: begin
                fc_d = fc_dec;
                if (fc_dec == 24'd0) begin
                  phase_d = PhEntLen;
                  fc_d    = '0;
                  acc_d   = '0;
                end
              end
            endcase
          end
        end
      end
    endcase
  end

  // Final status, by priority, from the state after this byte.
  always_comb begin
    if (phase_d < PhEntLen) begin
      st = StTruncated;
    end else if (mism_d || lrem_d != 24'd0) begin
      st = StMismatch;
    end else if (bad_d) begin
      st = StBadEntry;
    end else if (kept_d == 4'd0) begin
      st = StNone;
    end else begin
      st = StOk;
    end
  end

  // Result beat: the status on the last byte, else a kept certificate byte.
  always_comb begin
    res = '0;
    if (beat_i.in_last) begin
      res.out_kind   = KindStatus;
      res.status     = st;
      res.cert_count = kept_d;
    end else begin
      res.out_kind   = KindByte;
      res.cert_byte  = b;
      res.cert_index = 3'(kept_q - 4'd1);
      res.cert_end   = (fc_dec == 24'd0);
    end
  end

  assign res_valid_o = step && (beat_i.in_last || emit);
  assign res_o       = res;

  // Parser state; the last byte of a message clears it for the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr;
      fc_q    <= '0;
      acc_q   <= '0;
      lrem_q  <= '0;
      kept_q  <= '0;
      seen_q  <= 1'b0;
      mism_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else if (step) begin
      if (beat_i.in_last) begin
        phase_q <= PhHdr;
        fc_q    <= '0;
        acc_q   <= '0;
        lrem_q  <= '0;
        kept_q  <= '0;
        seen_q  <= 1'b0;
        mism_q  <= 1'b0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        fc_q    <= fc_d;
        acc_q   <= acc_d;
        lrem_q  <= lrem_d;
        kept_q  <= kept_d;
        seen_q  <= seen_d;
        mism_q  <= mism_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcmp_res_reg.sv =====
`default_nettype none

module tcmp_res_reg (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     res_valid_i,
  input  tcmp_pkg::result_beat_t  res_i,
  output logic                    up_ready_o,
  output logic                    out_valid_o,
  output tcmp_pkg::result_beat_t  out_o,
  input  wire                     out_ready_i
);

  logic                   valid_q;
  tcmp_pkg::result_beat_t res_q;

  // The register can load when empty or when its beat is taken now.
  assign up_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/tls13_certificate_message_parser_top.sv =====
`default_nettype none

// TLS 1.3 Certificate message parser. Feed the whole handshake message one
// byte per beat, header first, with in_last on its final byte. Bytes of the
// first eight certificates come out with their index and an end marker; the
// final byte yields only a status beat (ok, truncated before the list, list
// mismatch, bad entry, no certificates) with the count kept, and the parser
// then clears for the next message. Throughput is one byte per clock cycle
// while the output is not stalled; a byte goes through an input register and
// the parse logic into a result register before it reaches the output. Input
// ready depends combinationally on output ready.
module tls13_certificate_message_parser_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  tcmp_in_if.sink    in_i,
  tcmp_out_if.source out_o
);

  tcmp_pkg::byte_beat_t   in_beat;
  tcmp_pkg::byte_beat_t   beat;
  tcmp_pkg::result_beat_t res;
  tcmp_pkg::result_beat_t out_beat;
  logic                   beat_valid;
  logic                   res_valid;
  logic                   res_ready;

  assign in_beat.in_byte = in_i.in_byte;
  assign in_beat.in_last = in_i.in_last;

  // Input register.
  tcmp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_beat_i    (in_beat),
    .in_ready_o   (in_i.ready),
    .down_ready_i (res_ready),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  // Message walk and result formation.
  tcmp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .down_ready_i (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register.
  tcmp_res_reg u_res_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .up_ready_o  (res_ready),
    .out_valid_o (out_o.valid),
    .out_o       (out_beat),
    .out_ready_i (out_o.ready)
  );

  assign out_o.out_kind   = out_beat.out_kind;
  assign out_o.cert_byte  = out_beat.cert_byte;
  assign out_o.cert_index = out_beat.cert_index;
  assign out_o.cert_end   = out_beat.cert_end;
  assign out_o.status     = out_beat.status;
  assign out_o.cert_count = out_beat.cert_count;

endmodule

`default_nettype wire
